// ===== rtl/dashed_line_rasterizer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dashed line rasterizer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DASHED_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DASHED_LINE_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication
`define DLR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlr assertion failed");

// next-cycle implication
`define DLR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlr assertion failed");

`endif

// ===== rtl/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants, types and helpers of the dashed line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 128;
	localparam int FB_DEPTH      = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
	localparam int COL_W         = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int ROW_W         = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

	localparam int COORD_W     = 16;
	localparam int CLIP_W      = 16;
	localparam int PIX_W       = 8;
	localparam int DASH_W      = 8;
	localparam int CNT_W       = 17;
	localparam int ERR_W       = 19;
	localparam int IDX_W       = 3;
	localparam int TDATA_IN_W  = 96;
	localparam int TDATA_OUT_W = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_TOP    = 3'd1,
		REG_CLIP_RIGHT  = 3'd2,
		REG_CLIP_BOTTOM = 3'd3,
		REG_COLOUR_MODE = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_DRAW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CLIP_W-1:0] left;
		logic [CLIP_W-1:0] top;
		logic [CLIP_W-1:0] right;
		logic [CLIP_W-1:0] bottom;
	} clip_cfg_t;

	typedef struct packed {
		logic in_clip;
		logic last;
	} walk_st_t;

	typedef struct packed {
		logic busy;
		logic on;
	} dash_st_t;

	function automatic logic [ADDR_W-1:0] fb_addr(logic [ROW_W-1:0] row,
		logic [COL_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(col);
	endfunction

	function automatic logic on_screen(logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y);
		return (x >= 0) && (y >= 0) &&
			(x < $signed(COORD_W'(SCREEN_WIDTH))) &&
			(y < $signed(COORD_W'(SCREEN_HEIGHT)));
	endfunction

endpackage

// ===== rtl/dlr_ram.sv =====
// ----------------------------------------------------------------------------
// dlr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/dlr_dash.sv =====
// ----------------------------------------------------------------------------
// dlr_dash
// Dash pattern tracker: a bit-serial divide of the phase by the dash length
// seeds remainder and quotient parity, then both follow the wrapping counter.
// ----------------------------------------------------------------------------
module dlr_dash (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [dlr_pkg::DASH_W-1:0]    phase,
	input  logic [dlr_pkg::DASH_W-1:0]    length,
	input  logic                          step,
	output dlr_pkg::dash_st_t             st
);

	import dlr_pkg::*;

	localparam int BIT_W = $clog2(DASH_W);

	logic              busy_q;
	logic [BIT_W-1:0]  bit_q;
	logic [DASH_W-1:0] num_q;
	logic [DASH_W-1:0] len_q;
	logic [DASH_W-1:0] cnt_q;
	logic [DASH_W-1:0] rem_q;
	logic              par_q;
	logic [DASH_W:0]   rem_sh;
	logic              q_bit;
	logic [DASH_W:0]   rem_red;
	logic [DASH_W-1:0] rem_inc;

	always_comb begin
		rem_sh  = {rem_q, num_q[DASH_W-1]};
		q_bit   = rem_sh >= {1'b0, len_q};
		rem_red = q_bit ? (rem_sh - {1'b0, len_q}) : rem_sh;
		rem_inc = rem_q + DASH_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			bit_q  <= BIT_W'(DASH_W - 1);
		end else if (busy_q) begin
			bit_q <= bit_q - BIT_W'(1);
			if (bit_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= phase;
			cnt_q <= phase;
			len_q <= (length == '0) ? DASH_W'(1) : length;
			rem_q <= '0;
			par_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[DASH_W-2:0], 1'b0};
			rem_q <= rem_red[DASH_W-1:0];
			par_q <= q_bit;
		end else if (step) begin
			cnt_q <= cnt_q + DASH_W'(1);
			if (cnt_q == '1) begin
				rem_q <= '0;
				par_q <= 1'b0;
			end else if (rem_inc == len_q) begin
				rem_q <= '0;
				par_q <= ~par_q;
			end else begin
				rem_q <= rem_inc;
			end
		end
	end

	assign st.busy = busy_q;
	assign st.on   = ~par_q;

endmodule

// ===== rtl/dlr_walker.sv =====
// ----------------------------------------------------------------------------
// dlr_walker
// All-octant Bresenham stepper, one pixel per step, with clip test and
// framebuffer address of the current pixel.
// ----------------------------------------------------------------------------
module dlr_walker (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                step,
	input  logic signed [dlr_pkg::COORD_W-1:0]  x0,
	input  logic signed [dlr_pkg::COORD_W-1:0]  y0,
	input  logic signed [dlr_pkg::COORD_W-1:0]  x1,
	input  logic signed [dlr_pkg::COORD_W-1:0]  y1,
	input  dlr_pkg::clip_cfg_t                  clip,
	output dlr_pkg::walk_st_t                   st,
	output logic [dlr_pkg::ADDR_W-1:0]          addr
);

	import dlr_pkg::*;

	logic signed [COORD_W-1:0] x_q, y_q, xe_q, ye_q;
	logic signed [ERR_W-1:0]   dx_q, dy_q, err_q;
	logic                      sx_neg_q, sy_neg_q;

	logic signed [ERR_W-1:0]   dxd, dyd, adx, ady;
	logic signed [ERR_W:0]     e2;
	logic                      mov_x, mov_y;
	logic signed [ERR_W-1:0]   err_n;
	logic signed [COORD_W:0]   xw, yw, left_w, top_w, right_w, bottom_w;

	always_comb begin
		dxd   = $signed({{(ERR_W-COORD_W){x1[COORD_W-1]}}, x1}) -
			$signed({{(ERR_W-COORD_W){x0[COORD_W-1]}}, x0});
		dyd   = $signed({{(ERR_W-COORD_W){y1[COORD_W-1]}}, y1}) -
			$signed({{(ERR_W-COORD_W){y0[COORD_W-1]}}, y0});
		adx   = dxd[ERR_W-1] ? -dxd : dxd;
		ady   = dyd[ERR_W-1] ? -dyd : dyd;

		e2    = $signed({err_q, 1'b0});
		mov_x = e2 >= $signed({dy_q[ERR_W-1], dy_q});
		mov_y = e2 <= $signed({dx_q[ERR_W-1], dx_q});
		err_n = err_q + (mov_x ? dy_q : '0) + (mov_y ? dx_q : '0);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q      <= x0;
			y_q      <= y0;
			xe_q     <= x1;
			ye_q     <= y1;
			dx_q     <= adx;
			dy_q     <= -ady;
			err_q    <= adx - ady;
			sx_neg_q <= !(x0 < x1);
			sy_neg_q <= !(y0 < y1);
		end else if (step) begin
			err_q <= err_n;
			if (mov_x) begin
				x_q <= sx_neg_q ? (x_q - COORD_W'(1)) : (x_q + COORD_W'(1));
			end
			if (mov_y) begin
				y_q <= sy_neg_q ? (y_q - COORD_W'(1)) : (y_q + COORD_W'(1));
			end
		end
	end

	always_comb begin
		xw       = $signed({x_q[COORD_W-1], x_q});
		yw       = $signed({y_q[COORD_W-1], y_q});
		left_w   = $signed({1'b0, clip.left});
		top_w    = $signed({1'b0, clip.top});
		right_w  = (clip.right == '0) ? $signed((COORD_W + 1)'(SCREEN_WIDTH)) :
			$signed({1'b0, clip.right});
		bottom_w = (clip.bottom == '0) ? $signed((COORD_W + 1)'(SCREEN_HEIGHT)) :
			$signed({1'b0, clip.bottom});
		st.in_clip = (xw >= left_w) && (xw < right_w) && (yw >= top_w) &&
			(yw < bottom_w) && on_screen(x_q, y_q);
		st.last    = (x_q == xe_q) && (y_q == ye_q);
		addr       = fb_addr(y_q[ROW_W-1:0], x_q[COL_W-1:0]);
	end

endmodule

// ===== rtl/dashed_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// dashed_line_rasterizer_core
// Dashed Bresenham line rasterizer over an 8-bit indexed framebuffer.
// ----------------------------------------------------------------------------
// After reset the framebuffer is cleared one pixel per cycle, all 16384 pixels
// (SCREEN_WIDTH * SCREEN_HEIGHT); no request is taken during that pass, config
// writes are. One request is worked at a time; a finished result waits in the
// output register while the next request is taken. A read is accepted, then
// returns the registered RAM read. A draw walks N = max(|dx|, |dy|) + 1 line
// pixels: setup runs the 8 steps of the bit-serial phase/length divide, then
// the walk starts, and the line is drawn one pixel per cycle through the
// single framebuffer write port.
module dashed_line_rasterizer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// config port
	input  logic                               cfg_we,
	input  logic [dlr_pkg::IDX_W-1:0]          cfg_index,
	input  logic [dlr_pkg::CLIP_W-1:0]         cfg_wdata,
	// request stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// start_x, start_y, end_x, end_y, ink, dash_enable, dash_phase,
	// dash_length, zero pad
	input  logic [dlr_pkg::TDATA_IN_W-1:0]     s_tdata,
	// req_type
	input  logic                               s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// read_data, pixels_written, zero pad
	output logic [dlr_pkg::TDATA_OUT_W-1:0]    m_tdata
);

	import dlr_pkg::*;

	state_t state_q, state_d;

	clip_cfg_t  clip_q;
	logic       colour_mode_q;

	logic [ADDR_W-1:0] clr_q;
	logic [PIX_W-1:0]  ink_q;
	logic              dash_en_q;
	logic              is_read_q;
	logic              off_q;
	logic [CNT_W-1:0]  count_q;

	logic              out_valid_q;
	logic [PIX_W-1:0]  read_q;
	logic [CNT_W-1:0]  pixels_q;

	logic signed [COORD_W-1:0] in_sx, in_sy, in_ex, in_ey;
	logic [PIX_W-1:0]  in_ink;
	logic              in_dash_en;
	logic [DASH_W-1:0] in_phase, in_len;

	logic              accept;
	logic              plot;
	logic              out_load;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [PIX_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [PIX_W-1:0]  ram_rdata;
	logic [ADDR_W-1:0] walk_addr;
	walk_st_t          walk_st;
	dash_st_t          dash_st;

	assign in_sx      = $signed(s_tdata[15:0]);
	assign in_sy      = $signed(s_tdata[31:16]);
	assign in_ex      = $signed(s_tdata[47:32]);
	assign in_ey      = $signed(s_tdata[63:48]);
	assign in_ink     = s_tdata[71:64];
	assign in_dash_en = s_tdata[72];
	assign in_phase   = s_tdata[80:73];
	assign in_len     = s_tdata[88:81];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q        <= '0;
			colour_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLIP_LEFT:   clip_q.left   <= cfg_wdata;
				REG_CLIP_TOP:    clip_q.top    <= cfg_wdata;
				REG_CLIP_RIGHT:  clip_q.right  <= cfg_wdata;
				REG_CLIP_BOTTOM: clip_q.bottom <= cfg_wdata;
				REG_COLOUR_MODE: colour_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = walk_addr;
		ram_wdata = ink_q;
		plot      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(FB_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = s_tuser ? ST_DONE : ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (!dash_st.busy) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				plot   = walk_st.in_clip && (!dash_en_q || dash_st.on);
				ram_we = plot;
				if (walk_st.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;
	assign ram_re = accept && s_tuser;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ink_q     <= colour_mode_q ? in_ink : {{(PIX_W-1){1'b0}}, |in_ink};
			dash_en_q <= in_dash_en;
			is_read_q <= s_tuser;
			off_q     <= !on_screen(in_sx, in_sy);
			count_q   <= '0;
		end else if (plot) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_q   <= (is_read_q && !off_q) ? ram_rdata : '0;
			pixels_q <= is_read_q ? '0 : count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_OUT_W'({pixels_q, read_q});

	dlr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (FB_DEPTH)
	) u_fb (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (fb_addr(in_sy[ROW_W-1:0], in_sx[COL_W-1:0])),
		.rdata (ram_rdata)
	);

	dlr_walker u_walker (
		.clk   (clk),
		.load  (accept && !s_tuser),
		.step  ((state_q == ST_DRAW) && !walk_st.last),
		.x0    (in_sx),
		.y0    (in_sy),
		.x1    (in_ex),
		.y1    (in_ey),
		.clip  (clip_q),
		.st    (walk_st),
		.addr  (walk_addr)
	);

	dlr_dash u_dash (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && !s_tuser),
		.phase  (in_phase),
		.length (in_len),
		.step   (state_q == ST_DRAW),
		.st     (dash_st)
	);

`include "dashed_line_rasterizer_core_assert.svh"

	`DLR_ASSERT_NOW(a_no_req_in_clear, state_q == ST_CLEAR, !s_tready)
	`DLR_ASSERT_NOW(a_fb_write_src, ram_we, (state_q == ST_CLEAR) || (state_q == ST_DRAW))
	`DLR_ASSERT_NEXT(a_read_to_done, s_tvalid && s_tready && s_tuser, state_q == ST_DONE)
	`DLR_ASSERT_NOW(a_draw_after_div, state_q == ST_DRAW, !dash_st.busy)

endmodule

// ===== bench/dlr_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_tb_pkg
// Request codes and the request record shared by the rasterizer bench files.
// ----------------------------------------------------------------------------
package dlr_tb_pkg;

	typedef enum logic {
		REQ_DRAW = 1'b0,
		REQ_READ = 1'b1
	} req_kind_t;

	typedef struct {
		req_kind_t          kind;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic [7:0]         ink;
		logic               dash_en;
		logic [7:0]         phase;
		logic [7:0]         seg_len;
	} raster_req_t;

endpackage

// ===== bench/dlr_result_checker.sv =====
// ----------------------------------------------------------------------------
// dlr_result_checker
// Watches the config port and both streams of the rasterizer, keeps a shadow
// framebuffer, predicts the result of every accepted request and compares
// each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module dlr_result_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dlr_pkg::IDX_W-1:0]          cfg_index,
	input  logic [dlr_pkg::CLIP_W-1:0]         cfg_wdata,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// start_x, start_y, end_x, end_y, ink, dash_enable, dash_phase,
	// dash_length, zero pad
	input  logic [dlr_pkg::TDATA_IN_W-1:0]     s_tdata,
	// req_type
	input  logic                               s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// read_data, pixels_written, zero pad
	input  logic [dlr_pkg::TDATA_OUT_W-1:0]    m_tdata,
	output int                                 fail_count,
	output int                                 pending_count
);
	import dlr_pkg::*;
	import dlr_tb_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CNT_W-1:0] written;
	} raster_result_t;

	raster_result_t    due_results[$];
	logic [PIX_W-1:0]  fb_shadow [FB_DEPTH];
	logic [CLIP_W-1:0] clip_l, clip_t, clip_r, clip_b;
	logic              colour_on;
	raster_req_t       seen_req;
	raster_result_t    got_res, want_res;

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic logic [PIX_W-1:0] fetch_pixel(int x, int y);
		if (x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT)
			return fb_shadow[y * SCREEN_WIDTH + x];
		return '0;
	endfunction

	function automatic bit plot_pixel(int x, int y, logic [PIX_W-1:0] ink);
		int right, bottom;
		right  = (clip_r == 0) ? SCREEN_WIDTH : int'(clip_r);
		bottom = (clip_b == 0) ? SCREEN_HEIGHT : int'(clip_b);
		if (x < int'(clip_l) || y < int'(clip_t) || x >= right || y >= bottom)
			return 1'b0;
		if (x < 0 || y < 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT)
			return 1'b0;
		fb_shadow[y * SCREEN_WIDTH + x] = colour_on ? ink : PIX_W'(ink != 0);
		return 1'b1;
	endfunction

	function automatic logic [CNT_W-1:0] trace_line(raster_req_t rq);
		int x, y, xe, ye, dx, dy, stx, sty, err, e2, seg;
		logic [DASH_W-1:0] dash_cnt;
		logic [CNT_W-1:0]  n;
		x   = rq.sx;
		y   = rq.sy;
		xe  = rq.ex;
		ye  = rq.ey;
		dx  = (xe > x) ? xe - x : x - xe;
		dy  = -((ye > y) ? ye - y : y - ye);
		stx = (x < xe) ? 1 : -1;
		sty = (y < ye) ? 1 : -1;
		err = dx + dy;
		dash_cnt = rq.phase;
		n   = '0;
		// zero dash length counts as one
		seg = (rq.seg_len == 0) ? 1 : int'(rq.seg_len);
		forever begin
			if (!rq.dash_en || (((int'(dash_cnt) / seg) % 2) == 0))
				n = n + plot_pixel(x, y, rq.ink);
			dash_cnt = dash_cnt + 1'b1;
			if (x == xe && y == ye)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x   += stx;
			end
			if (e2 <= dx) begin
				err += dx;
				y   += sty;
			end
		end
		return n;
	endfunction

	function automatic raster_result_t predict_request(raster_req_t rq);
		raster_result_t res;
		res = '0;
		if (rq.kind == REQ_READ)
			res.pixel = fetch_pixel(rq.sx, rq.sy);
		else
			res.written = trace_line(rq);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (fb_shadow[i])
				fb_shadow[i] = '0;
			clip_l        = '0;
			clip_t        = '0;
			clip_r        = '0;
			clip_b        = '0;
			colour_on     = 1'b1;
			fail_count    = 0;
			pending_count = 0;
			due_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLIP_LEFT:   clip_l = cfg_wdata;
					REG_CLIP_TOP:    clip_t = cfg_wdata;
					REG_CLIP_RIGHT:  clip_r = cfg_wdata;
					REG_CLIP_BOTTOM: clip_b = cfg_wdata;
					REG_COLOUR_MODE: colour_on = cfg_wdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got_res.pixel   = m_tdata[7:0];
				got_res.written = m_tdata[24:8];
				if (due_results.size() == 0) begin
					report("result with no request", got_res.written, 0);
				end else begin
					want_res = due_results.pop_front();
					if (got_res.pixel !== want_res.pixel)
						report("read_data", got_res.pixel, want_res.pixel);
					if (got_res.written !== want_res.written)
						report("pixels_written", got_res.written, want_res.written);
				end
			end
			if (s_tvalid && s_tready) begin
				seen_req.kind    = req_kind_t'(s_tuser);
				seen_req.sx      = s_tdata[15:0];
				seen_req.sy      = s_tdata[31:16];
				seen_req.ex      = s_tdata[47:32];
				seen_req.ey      = s_tdata[63:48];
				seen_req.ink     = s_tdata[71:64];
				seen_req.dash_en = s_tdata[72];
				seen_req.phase   = s_tdata[80:73];
				seen_req.seg_len = s_tdata[88:81];
				due_results.push_back(predict_request(seen_req));
			end
			pending_count = due_results.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the dashed line rasterizer with directed and random draw and read
// requests under bursty input and a stalling result side, steps through
// several clip and colour settings, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import dlr_pkg::*;
	import dlr_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 250;
	localparam int SETTLE_CYCLES  = 16;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CLIP_W-1:0]      cfg_wdata = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	int                     fail_count;
	int                     pending_count;
	int                     idle_cycles = 0;
	int                     burst_left  = 0;
	int                     rx_mode     = 0;
	int                     rx_left     = 0;
	int                     last_x      = 0;
	int                     last_y      = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	dashed_line_rasterizer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	dlr_result_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[dashed_line_rasterizer_core] ERROR");
			$finish;
		end
	end

	// result side stalls in modes of random length
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(8, 200);
		end
		rx_left = rx_left - 1;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= ((rx_left % 6) != 0);
		endcase
	end

	function automatic raster_req_t make_req(req_kind_t kind, int x0, int y0, int x1, int y1,
		int ink, int dash_en, int phase, int seg);
		raster_req_t rq;
		rq.kind    = kind;
		rq.sx      = 16'(x0);
		rq.sy      = 16'(y0);
		rq.ex      = 16'(x1);
		rq.ey      = 16'(y1);
		rq.ink     = 8'(ink);
		rq.dash_en = 1'(dash_en);
		rq.phase   = 8'(phase);
		rq.seg_len = 8'(seg);
		return rq;
	endfunction

	function automatic int near_coord();
		return int'($urandom_range(0, 159)) - 16;
	endfunction

	function automatic int full_coord();
		return int'($signed(16'($urandom)));
	endfunction

	function automatic int clamp_coord(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic raster_req_t random_req();
		raster_req_t rq;
		int pick, x0, y0, x1, y1;
		pick = $urandom_range(0, 99);
		x0 = near_coord();
		y0 = near_coord();
		x1 = near_coord();
		y1 = near_coord();
		rq = make_req(REQ_DRAW, 0, 0, 0, 0, 0, 0, 0, 0);
		rq.ink     = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
		rq.dash_en = 1'($urandom_range(0, 1));
		rq.phase   = 8'($urandom);
		rq.seg_len = $urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom);
		if ($urandom_range(0, 499) == 0) begin
			x0 = full_coord();
			y0 = full_coord();
			x1 = full_coord();
			y1 = full_coord();
		end else if (pick < 40) begin
		end else if (pick < 45) begin
			x0 = full_coord();
			y0 = full_coord();
			x1 = clamp_coord(x0 + int'($urandom_range(0, 80)) - 40);
			y1 = clamp_coord(y0 + int'($urandom_range(0, 80)) - 40);
		end else if (pick < 75) begin
			rq.kind = REQ_READ;
			x0 = $urandom_range(0, SCREEN_WIDTH - 1);
			y0 = $urandom_range(0, SCREEN_HEIGHT - 1);
		end else if (pick < 80) begin
			rq.kind = REQ_READ;
			x0 = full_coord();
			y0 = full_coord();
		end else if (pick < 90) begin
			rq.kind = REQ_READ;
			x0 = last_x;
			y0 = last_y;
		end else begin
			x0 = $urandom_range(0, SCREEN_WIDTH - 1);
			y0 = $urandom_range(0, SCREEN_HEIGHT - 1);
			x1 = x0 + int'($urandom_range(0, 24)) - 12;
			y1 = y0 + int'($urandom_range(0, 24)) - 12;
		end
		if (rq.kind == REQ_DRAW) begin
			last_x = $urandom_range(0, 1) ? x0 : x1;
			last_y = (last_x == x0) ? y0 : y1;
		end
		rq.sx = 16'(x0);
		rq.sy = 16'(y0);
		rq.ex = 16'(x1);
		rq.ey = 16'(y1);
		return rq;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [CLIP_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_setting(int p);
		logic [CLIP_W-1:0] l, t, r, b;
		logic c;
		case (p)
			0: begin
				l = 0; t = 0; r = 0; b = 0; c = 1'b1;
			end
			1: begin
				l = 0; t = 0; r = 0; b = 0; c = 1'b0;
			end
			2: begin
				l = 16; t = 8; r = 100; b = 120; c = 1'b1;
			end
			3: begin
				l = 0; t = 0; r = 16'hFFFF; b = 16'hFFFF; c = 1'b0;
			end
			4: begin
				l = 16'hFFFF; t = 16'hFFFF; r = 0; b = 0; c = 1'b1;
			end
			5: begin
				l = 0; t = 0; r = 1; b = 1; c = 1'b0;
			end
			default: begin
				l = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 140));
				t = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 140));
				r = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 160));
				b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 160));
				c = 1'($urandom_range(0, 1));
			end
		endcase
		write_reg(REG_CLIP_LEFT, l);
		write_reg(REG_CLIP_TOP, t);
		write_reg(REG_CLIP_RIGHT, r);
		write_reg(REG_CLIP_BOTTOM, b);
		write_reg(REG_COLOUR_MODE, CLIP_W'(c));
	endtask

	task automatic idle_sender(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic push_request(raster_req_t rq);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= rq.kind;
		s_tdata  <= {7'd0, rq.seg_len, rq.phase, rq.dash_en, rq.ink,
			rq.ey, rq.ex, rq.sy, rq.sx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_req(raster_req_t rq);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 30));
		end
		burst_left--;
		push_request(rq);
	endtask

	// wait until every request is answered and the core has settled
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		raster_req_t directed[$];
		int p, k;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// writes are taken during the clear pass
		apply_setting(0);

		directed.push_back(make_req(REQ_DRAW, 0, 0, 0, 0, 255, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, -5, 0, 132, 0, 8'h5A, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 127, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 128, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, -1, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, 10, 127, 10, -3, 8'h33, 1, 0, 0));
		directed.push_back(make_req(REQ_READ, 10, 126, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, 100, 100, 3, 20, 8'hC7, 1, 250, 3));
		directed.push_back(make_req(REQ_DRAW, 3, 120, 120, 7, 8'h81, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, 64, 64, 70, 127, 8'h7E, 1, 255, 255));
		directed.push_back(make_req(REQ_DRAW, 20, 5, 5, 9, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 20, 5, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, 32767, 32767, 32767, 32767, 8'hAA, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, -32768, -32768, -32768, -32768, 8'h55, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, -32768, 5, 32767, 5, 8'h11, 1, 128, 2));
		directed.push_back(make_req(REQ_READ, -32768, 32767, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 32767, -32768, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 5, 5, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, 127, 127, 0, 0, 8'hFE, 1, 7, 1));
		directed.push_back(make_req(REQ_READ, 127, 127, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_req(REQ_DRAW, -32768, -32768, 32767, 32767, 1, 0, 0, 0));
		directed.push_back(make_req(REQ_READ, 64, 64, 0, 0, 0, 0, 0, 0));
		foreach (directed[i])
			send_req(directed[i]);

		for (p = 1; p <= RANDOM_PHASES; p++) begin
			drain();
			apply_setting(p);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_req(random_req());
		end
		drain();

		if (fail_count == 0)
			$display("[dashed_line_rasterizer_core] OK");
		else
			$display("[dashed_line_rasterizer_core] ERROR");
		$finish;
	end

endmodule
